FILE: src/stvd_pkg.sv
// Shared types and constants for the typed sensor value decoder.
package stvd_pkg;

  // Largest byte count a sensor value may report
  localparam int unsigned MAX_VALUE_BYTES = 32;

  // Depth of the request queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Four-character type and key codes, first character in the top byte
  localparam logic [31:0] TYPE_FLT  = 32'h666c_7420;  // "flt "
  localparam logic [31:0] TYPE_IOFT = 32'h696f_6674;  // "ioft"
  localparam logic [31:0] TYPE_UI8  = 32'h7569_3820;  // "ui8 "
  localparam logic [31:0] TYPE_UI16 = 32'h7569_3136;  // "ui16"
  localparam logic [31:0] TYPE_UI32 = 32'h7569_3332;  // "ui32"
  localparam logic [31:0] TYPE_SI8  = 32'h7369_3820;  // "si8 "
  localparam logic [31:0] TYPE_SI16 = 32'h7369_3136;  // "si16"
  localparam logic [31:0] TYPE_SI32 = 32'h7369_3332;  // "si32"
  localparam logic [31:0] TYPE_SP78 = 32'h7370_3738;  // "sp78"
  localparam logic [31:0] KEY_TA0P  = 32'h5461_3050;  // "Ta0P"

  localparam logic [7:0] CHAR_F = 8'h66;
  localparam logic [7:0] CHAR_S = 8'h73;
  localparam logic [7:0] CHAR_P = 8'h70;

  // Upper temperature bound, 150.0 in Q47.16
  localparam logic [63:0] TEMP_MAX_Q = 64'h0000_0000_0096_0000;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TYPE  = 2'd1,
    ST_RANGE = 2'd2,
    ST_TEMP  = 2'd3
  } stvd_status_e;

  // Conversion class chosen by the front
  typedef enum logic [1:0] {
    KIND_ERR  = 2'd0,
    KIND_FLT  = 2'd1,
    KIND_IOFT = 2'd2,
    KIND_INT  = 2'd3
  } stvd_kind_e;

  // Big-endian integer width for fixed and integer types
  typedef enum logic [1:0] {
    W8  = 2'd0,
    W16 = 2'd1,
    W32 = 2'd2
  } stvd_width_e;

  // Classified request passed from front to back
  typedef struct packed {
    stvd_kind_e  kind;
    stvd_width_e width;
    logic        sign_ext;
    logic [4:0]  lshift;
    logic        action;
    logic [63:0] bytes;
  } stvd_req_t;

  // Queue status toward the input channel and checks
  typedef struct packed {
    logic full;
    logic empty;
  } stvd_qstat_t;

endpackage

FILE: src/stvd_front.sv
// Front end: classifies an incoming sensor value by type code, key and size.
module stvd_front (
  input  logic              action_i,
  input  logic [31:0]       key_code_i,
  input  logic [31:0]       type_code_i,
  input  logic [5:0]        value_size_i,
  input  logic [63:0]       value_bytes_i,
  output stvd_pkg::stvd_req_t req_o
);

  localparam logic [7:0] MaxBytes = 8'(stvd_pkg::MAX_VALUE_BYTES);

  // Hex fraction digit: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

  logic        size_ok;
  logic [31:0] eff_type;
  logic [7:0]  c0;
  logic [7:0]  c1;
  logic [4:0]  digit;

  // Temperature key override and size limit
  assign size_ok  = {2'b00, value_size_i} <= MaxBytes;
  assign eff_type = (action_i && key_code_i == stvd_pkg::KEY_TA0P && value_size_i >= 6'd2)
                    ? stvd_pkg::TYPE_SP78 : type_code_i;
  assign c0       = eff_type[31:24];
  assign c1       = eff_type[23:16];
  assign digit    = hex_digit(eff_type[7:0]);

  // Type classification
  always_comb begin
    req_o          = '0;
    req_o.kind     = stvd_pkg::KIND_ERR;
    req_o.width    = stvd_pkg::W16;
    req_o.sign_ext = 1'b0;
    req_o.lshift   = 5'd16;
    req_o.action   = action_i;
    req_o.bytes    = value_bytes_i;
    priority if (!size_ok) begin
      req_o.kind = stvd_pkg::KIND_ERR;
    end else if (eff_type == stvd_pkg::TYPE_FLT && value_size_i >= 6'd4) begin
      req_o.kind = stvd_pkg::KIND_FLT;
    end else if (eff_type == stvd_pkg::TYPE_IOFT && value_size_i >= 6'd8) begin
      req_o.kind = stvd_pkg::KIND_IOFT;
    end else if ((c0 == stvd_pkg::CHAR_F || c0 == stvd_pkg::CHAR_S) &&
                 c1 == stvd_pkg::CHAR_P) begin
      // fpXY / spXY: 16-bit value, Y fraction bits
      if (value_size_i >= 6'd2 && digit[4]) begin
        req_o.kind     = stvd_pkg::KIND_INT;
        req_o.width    = stvd_pkg::W16;
        req_o.sign_ext = (c0 == stvd_pkg::CHAR_S);
        req_o.lshift   = 5'd16 - {1'b0, digit[3:0]};
      end
    end else if (eff_type == stvd_pkg::TYPE_UI8 && value_size_i >= 6'd1) begin
      req_o.kind  = stvd_pkg::KIND_INT;
      req_o.width = stvd_pkg::W8;
    end else if (eff_type == stvd_pkg::TYPE_UI16 && value_size_i >= 6'd2) begin
      req_o.kind  = stvd_pkg::KIND_INT;
      req_o.width = stvd_pkg::W16;
    end else if (eff_type == stvd_pkg::TYPE_UI32 && value_size_i >= 6'd4) begin
      req_o.kind  = stvd_pkg::KIND_INT;
      req_o.width = stvd_pkg::W32;
    end else if (eff_type == stvd_pkg::TYPE_SI8 && value_size_i >= 6'd1) begin
      req_o.kind     = stvd_pkg::KIND_INT;
      req_o.width    = stvd_pkg::W8;
      req_o.sign_ext = 1'b1;
    end else if (eff_type == stvd_pkg::TYPE_SI16 && value_size_i >= 6'd2) begin
      req_o.kind     = stvd_pkg::KIND_INT;
      req_o.width    = stvd_pkg::W16;
      req_o.sign_ext = 1'b1;
    end else if (eff_type == stvd_pkg::TYPE_SI32 && value_size_i >= 6'd4) begin
      req_o.kind     = stvd_pkg::KIND_INT;
      req_o.width    = stvd_pkg::W32;
      req_o.sign_ext = 1'b1;
    end else begin
      req_o.kind = stvd_pkg::KIND_ERR;
    end
  end

endmodule

FILE: src/stvd_queue.sv
// Short request queue decoupling the front from the back.
module stvd_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  input  stvd_pkg::stvd_req_t   push_req_i,
  input  logic                  pop_ready_i,
  output logic                  pop_valid_o,
  output stvd_pkg::stvd_req_t   pop_req_o,
  output stvd_pkg::stvd_qstat_t qstat_o
);

  localparam int unsigned Depth = stvd_pkg::QDEPTH;
  localparam int unsigned PtrW  = stvd_pkg::QPTR_W;
  localparam int unsigned CntW  = stvd_pkg::QCNT_W;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  stvd_pkg::stvd_req_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            pop;

  assign qstat_o.full  = (cnt_q == FullCnt);
  assign qstat_o.empty = (cnt_q == '0);
  assign pop_valid_o   = !qstat_o.empty;
  assign pop_req_o     = entry_q[rd_ptr_q];
  assign push          = push_valid_i && !qstat_o.full;
  assign pop           = pop_valid_o && pop_ready_i;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

FILE: src/stvd_back.sv
// Back end: converts a classified request to Q47.16 and holds the result register.
module stvd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                deq_valid_i,
  input  stvd_pkg::stvd_req_t deq_req_i,
  output logic                deq_ready_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [63:0]         value_o,
  output logic [1:0]          status_o
);

  logic [7:0]  b0, b1, b2, b3;
  logic        neg_int;
  logic [63:0] x64;
  logic [63:0] q_int;

  logic        f_neg;
  logic [7:0]  f_exp;
  logic [23:0] f_man;
  logic [7:0]  f_sh;
  logic [7:0]  f_rs;
  logic        f_big;
  logic        f_err;
  logic [63:0] f_mag;
  logic        f_inexact;
  logic [31:0] f_lowmask;

  logic [63:0] q;
  logic [63:0] cmp;
  logic        neg;
  logic        inexact;
  stvd_pkg::stvd_status_e st;
  logic        positive;
  logic        above;

  logic        out_valid_q, out_valid_d;
  logic [63:0] value_q;
  stvd_pkg::stvd_status_e status_q;

  assign b0 = deq_req_i.bytes[7:0];
  assign b1 = deq_req_i.bytes[15:8];
  assign b2 = deq_req_i.bytes[23:16];
  assign b3 = deq_req_i.bytes[31:24];

  // Big-endian integer and fixed point
  assign neg_int = deq_req_i.sign_ext && b0[7];
  always_comb begin
    unique case (deq_req_i.width)
      stvd_pkg::W8:  x64 = {{56{neg_int}}, b0};
      stvd_pkg::W16: x64 = {{48{neg_int}}, b0, b1};
      stvd_pkg::W32: x64 = {{32{neg_int}}, b0, b1, b2, b3};
      default:       x64 = '0;
    endcase
  end
  assign q_int = x64 << deq_req_i.lshift;

  // IEEE single to fixed, truncating toward zero
  assign f_neg = deq_req_i.bytes[31];
  assign f_exp = deq_req_i.bytes[30:23];
  assign f_man = {1'b1, deq_req_i.bytes[22:0]};
  assign f_big = f_exp >= 8'd134;
  assign f_sh  = f_exp - 8'd134;
  assign f_rs  = 8'd134 - f_exp;
  assign f_lowmask = (32'h1 << f_rs[4:0]) - 32'h1;
  // Only -2^47 survives a shift of 40
  assign f_err = (f_exp == 8'hff) ||
                 (f_big && ((f_sh > 8'd40) ||
                            (f_sh == 8'd40 && !(f_neg && deq_req_i.bytes[22:0] == 23'h0))));

  always_comb begin
    f_mag     = '0;
    f_inexact = 1'b0;
    if (f_exp == 8'h00) begin
      f_inexact = (deq_req_i.bytes[22:0] != 23'h0);
    end else if (f_big) begin
      f_mag = {40'h0, f_man} << f_sh[5:0];
    end else if (f_rs > 8'd31) begin
      f_inexact = 1'b1;
    end else begin
      f_mag     = {40'h0, f_man >> f_rs[4:0]};
      f_inexact = (({8'h00, f_man} & f_lowmask) != 32'h0);
    end
  end

  // Result select and temperature window
  always_comb begin
    q       = '0;
    cmp     = '0;
    neg     = 1'b0;
    inexact = 1'b0;
    st      = stvd_pkg::ST_TYPE;
    unique case (deq_req_i.kind)
      stvd_pkg::KIND_FLT: begin
        neg     = f_neg;
        inexact = f_inexact;
        q       = f_neg ? (64'h0 - f_mag) : f_mag;
        cmp     = f_mag;
        st      = f_err ? stvd_pkg::ST_RANGE : stvd_pkg::ST_OK;
      end
      stvd_pkg::KIND_IOFT: begin
        q   = deq_req_i.bytes;
        cmp = deq_req_i.bytes;
        st  = deq_req_i.bytes[63] ? stvd_pkg::ST_RANGE : stvd_pkg::ST_OK;
      end
      stvd_pkg::KIND_INT: begin
        neg = neg_int;
        q   = q_int;
        cmp = q_int;
        st  = stvd_pkg::ST_OK;
      end
      default: st = stvd_pkg::ST_TYPE;
    endcase
    positive = !neg && (cmp != 64'h0 || inexact);
    above    = !neg && (cmp > stvd_pkg::TEMP_MAX_Q ||
                        (cmp == stvd_pkg::TEMP_MAX_Q && inexact));
    if (st == stvd_pkg::ST_OK && deq_req_i.action && (!positive || above)) begin
      st = stvd_pkg::ST_TEMP;
    end
  end

  // Output register: refills whenever empty or being taken
  assign deq_ready_o = !out_valid_q || !out_stall_i;
  assign out_valid_d = deq_ready_o ? deq_valid_i : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (deq_ready_o && deq_valid_i) begin
      value_q  <= (st == stvd_pkg::ST_OK) ? q : 64'h0;
      status_q <= st;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

FILE: src/sensor_typed_value_decoder_core.sv
// Top level of the typed sensor value decoder: front, request queue and back.
//
// Input channel: in_valid_i/in_stall_o with action, key, type code, byte count
// and the first eight value bytes. A request is taken at a clock edge where
// in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o/out_stall_i with the Q47.16 value and status,
// one result per request, in order. decoded_value_o is zero on a bad status.
// A request taken at a clock edge is written into the queue; the back pops it
// and loads its result into the output register when the output side is free.
// Throughput: one request per cycle while out_stall_i allows; the front classifies
// in the cycle of acceptance and the back converts combinationally into the output register, so nothing iterates.
// The two-entry queue between front and back absorbs a stall: in_stall_o
// rises only once the output register holds a result under stall and the
// queue is full; results are held stable while out_stall_i is high.
// Reset (rst_ni low, asynchronous) empties the queue and the output register;
// the block keeps no other state and is ready right after reset.
module sensor_typed_value_decoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [31:0]        key_code_i,
  input  logic [31:0]        type_code_i,
  input  logic [5:0]         value_size_i,
  input  logic [63:0]        value_bytes_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] decoded_value_o,
  output logic [1:0]         status_o
);

  stvd_pkg::stvd_req_t   front_req;
  stvd_pkg::stvd_req_t   deq_req;
  stvd_pkg::stvd_qstat_t qstat;
  logic                  deq_valid;
  logic                  deq_ready;
  logic [63:0]           value;

  stvd_front u_front (
    .action_i      (action_i),
    .key_code_i    (key_code_i),
    .type_code_i   (type_code_i),
    .value_size_i  (value_size_i),
    .value_bytes_i (value_bytes_i),
    .req_o         (front_req)
  );

  stvd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_req_i   (front_req),
    .pop_ready_i  (deq_ready),
    .pop_valid_o  (deq_valid),
    .pop_req_o    (deq_req),
    .qstat_o      (qstat)
  );

  stvd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .deq_valid_i (deq_valid),
    .deq_req_i   (deq_req),
    .deq_ready_o (deq_ready),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .value_o     (value),
    .status_o    (status_o)
  );

  assign in_stall_o      = qstat.full;
  assign decoded_value_o = $signed(value);

`ifndef ASSERT_OFF
  // A failed decode never carries a value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != stvd_pkg::ST_OK) |-> (decoded_value_o == 64'sd0))
    else $error("nonzero value with error status");

  // A request taken into the queue is there at the next edge
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !qstat.empty)
    else $error("accepted request missing from queue");

  // A fresh result only comes from a queued request
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |=> (out_valid_o == $past(deq_valid)))
    else $error("output register loaded without a queued request");
`endif

endmodule
